// ===== rtl/tsd_pkg.sv =====
// tsd_pkg: shared types and constants for the tar stream deframer
`default_nettype none

package tsd_pkg;

  // Width of the parsed size value and of the file_size field
  localparam int SIZE_BITS = 31;

  // ustar header geometry
  localparam int BLOCK_LEN        = 512;
  localparam int POS_W            = 9;
  localparam int SIZE_FIELD_START = 124;
  localparam int SIZE_FIELD_LEN   = 12;
  localparam int SIZE_FIELD_END   = SIZE_FIELD_START + SIZE_FIELD_LEN - 1;
  localparam int TYPE_OFFSET      = 156;

  // Characters of interest
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_7       = 8'h37;
  localparam logic [7:0] TYPE_REGULAR = 8'h30;

  // Result queue between parser and output stage
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = Q_PTR_W + 1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } tsd_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } tsd_in_t;

  typedef struct packed {
    tsd_kind_t            kind;
    logic [7:0]           out_byte;
    logic [SIZE_BITS-1:0] file_size;
    logic                 last_of_file;
  } tsd_out_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } tsd_q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tsd_front.sv =====
// tsd_front: byte parser; classifies each archive byte and issues results
`default_nettype none

module tsd_front
  import tsd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire tsd_in_t  beat,
  output logic          push,
  output tsd_out_t      push_item
);

  typedef enum logic [4:0] {
    PH_HDR  = 5'b00001,
    PH_DATA = 5'b00010,
    PH_PAD  = 5'b00100,
    PH_DONE = 5'b01000,
    PH_ERR  = 5'b10000
  } tsd_phase_t;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);

  tsd_phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic                 seen_r, seen_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [7:0]           etype_r, etype_nxt;
  logic                 regular_r, regular_nxt;
  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  logic [POS_W-1:0]     pad_r, pad_nxt;

  logic [7:0] b;
  logic       data_last;

  assign b         = beat.data_byte;
  assign data_last = (rem_r <= SIZE_BITS'(1));

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    seen_nxt    = seen_r;
    stopped_nxt = stopped_r;
    ovf_nxt     = ovf_r;
    etype_nxt   = etype_r;
    regular_nxt = regular_r;
    rem_nxt     = rem_r;
    pad_nxt     = pad_r;
    push        = 1'b0;
    push_item   = '0;

    if (accept) begin
      if (phase_r == PH_ERR) begin
        push           = 1'b1;
        push_item.kind = KIND_ERROR;
      end else if (phase_r == PH_DONE) begin
        // archive closed: swallow everything
      end else if (beat.stream_end) begin
        push = 1'b1;
        if (phase_r == PH_HDR && pos_r == '0) begin
          phase_nxt      = PH_DONE;
          push_item.kind = KIND_END;
        end else begin
          phase_nxt      = PH_ERR;
          push_item.kind = KIND_ERROR;
        end
      end else begin
        case (phase_r)
          PH_HDR: begin
            // octal size field
            if (pos_r inside {[SIZE_FIELD_START:SIZE_FIELD_END]} && !stopped_r) begin
              if (b inside {[CHAR_0:CHAR_7]}) begin
                seen_nxt = 1'b1;
                if (!ovf_r) begin
                  if (|acc_r[SIZE_BITS-1 -: 3]) begin
                    ovf_nxt = 1'b1;
                  end else begin
                    acc_nxt = {acc_r[SIZE_BITS-4:0], b[2:0]};
                  end
                end
              end else if (b == CHAR_SPACE && !seen_r) begin
                // leading space
              end else begin
                stopped_nxt = 1'b1;
              end
            end
            if (pos_r == POS_W'(TYPE_OFFSET)) begin
              etype_nxt = b;
            end
            if (pos_r == POS_LAST) begin
              if (etype_r == CHAR_NUL) begin
                phase_nxt      = PH_DONE;
                push           = 1'b1;
                push_item.kind = KIND_END;
              end else if (!seen_r || ovf_r) begin
                phase_nxt      = PH_ERR;
                push           = 1'b1;
                push_item.kind = KIND_ERROR;
              end else begin
                regular_nxt = (etype_r == TYPE_REGULAR);
                rem_nxt     = acc_r;
                pad_nxt     = POS_W'(0) - acc_r[POS_W-1:0];
                phase_nxt   = (acc_r == '0) ? PH_HDR : PH_DATA;
                if (etype_r == TYPE_REGULAR) begin
                  push                   = 1'b1;
                  push_item.kind         = KIND_HEADER;
                  push_item.file_size    = acc_r;
                  push_item.last_of_file = (acc_r == '0);
                end
              end
              pos_nxt     = '0;
              acc_nxt     = '0;
              seen_nxt    = 1'b0;
              stopped_nxt = 1'b0;
              ovf_nxt     = 1'b0;
              etype_nxt   = CHAR_NUL;
            end else begin
              pos_nxt = pos_r + POS_W'(1);
            end
          end
          PH_DATA: begin
            rem_nxt = data_last ? '0 : rem_r - SIZE_BITS'(1);
            if (data_last) begin
              phase_nxt = (pad_r != '0) ? PH_PAD : PH_HDR;
            end
            if (regular_r) begin
              push                   = 1'b1;
              push_item.kind         = KIND_DATA;
              push_item.out_byte     = b;
              push_item.last_of_file = data_last;
            end
          end
          PH_PAD: begin
            if (pad_r <= POS_W'(1)) begin
              pad_nxt   = '0;
              phase_nxt = PH_HDR;
            end else begin
              pad_nxt = pad_r - POS_W'(1);
            end
          end
          default: begin
            phase_nxt = PH_ERR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR;
      pos_r     <= '0;
      acc_r     <= '0;
      seen_r    <= 1'b0;
      stopped_r <= 1'b0;
      ovf_r     <= 1'b0;
      etype_r   <= CHAR_NUL;
      regular_r <= 1'b0;
      rem_r     <= '0;
      pad_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      acc_r     <= acc_nxt;
      seen_r    <= seen_nxt;
      stopped_r <= stopped_nxt;
      ovf_r     <= ovf_nxt;
      etype_r   <= etype_nxt;
      regular_r <= regular_nxt;
      rem_r     <= rem_nxt;
      pad_r     <= pad_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tsd_queue.sv =====
// tsd_queue: small result FIFO between parser and output stage
`default_nettype none

module tsd_queue
  import tsd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire tsd_out_t push_item,
  input  wire logic     pop,
  output tsd_out_t      head,
  output tsd_q_stat_t   stat
);

  tsd_out_t           q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = q_mem_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tsd_back.sv =====
// tsd_back: output register that drains the result queue
`default_nettype none

module tsd_back
  import tsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire tsd_q_stat_t stat,
  input  wire tsd_out_t    head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output tsd_out_t         out_beat
);

  logic     valid_r;
  tsd_out_t beat_r;

  // refill when empty or when the held beat leaves this cycle
  assign pop       = !stat.empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= !stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      beat_r <= head;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tar_stream_deframer_unit.sv =====
// tar_stream_deframer_unit: top level of the streaming tar archive deframer
// Throughput: one archive byte per cycle, sustained, while out_stall stays low.
// A result beat is registered in the queue and then in the output register
//   before it shows on out_valid.
// A 4-entry queue lets the parser run on while the output side is stalled.
// Reset: synchronous, active-low rst_n; clears parser state and queue at once.
`default_nettype none

module tar_stream_deframer_unit
  import tsd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  // archive byte channel
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire tsd_in_t  in_beat,
  // result channel
  output logic          out_valid,
  input  wire logic     out_stall,
  output tsd_out_t      out_beat
);

  logic        accept;
  logic        push;
  tsd_out_t    push_item;
  logic        pop;
  tsd_out_t    head;
  tsd_q_stat_t q_stat;

  // Every byte yields at most one result, so one free queue slot is all
  // the parser needs to take a beat.
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // Front: header collection, size parse, data/padding counting
  tsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .beat      (in_beat),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue
  tsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Back: registered result beat
  tsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

`default_nettype wire

// ===== rtl/tsd_checker.sv =====
// tsd_checker: port-level assertions for the tar stream deframer, bound to the top
`default_nettype none

module tsd_checker
  import tsd_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire tsd_in_t  in_beat,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire tsd_out_t out_beat
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // end of archive is the final result ever issued
  a_end_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_beat.kind == KIND_END |=> !out_valid)
    else $error("result after end of archive");

  // error is sticky: the next result is an error too
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_beat.kind == KIND_ERROR |=>
      !out_valid || out_beat.kind == KIND_ERROR)
    else $error("error not sticky");

  // unused fields are zero; empty-file marking matches size
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_beat.kind == KIND_DATA || out_beat.out_byte == '0) &&
      (out_beat.kind != KIND_HEADER ||
        out_beat.last_of_file == (out_beat.file_size == '0)) &&
      (out_beat.kind == KIND_HEADER || out_beat.file_size == '0))
    else $error("inconsistent result fields");

  // reset empties the block
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not empty after reset");

endmodule

bind tar_stream_deframer_unit tsd_checker u_tsd_checker (.*);

`default_nettype wire
